// ===== design/prfc_pkg.sv =====
// Package for the prefix route filter counter block.
// Holds field widths, the table entry layout, kind codes, states and the prefix match.
// No dependencies; used by the top level, the checker and the testbench.
package prfc_pkg;

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int LINK_W  = 4;
   localparam int KIND_W  = 3;
   localparam int ENTRY_W = ADDR_W + LEN_W + LINK_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam int ROUTE_DEPTH_DEF  = 64;
   localparam int FILTER_DEPTH_DEF = 16;
   localparam int LINK_COUNT_DEF   = 16;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic [KIND_W-1:0] KIND_ADD_ROUTE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_FILTER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PACKET     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ_COUNT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

   typedef struct packed {
      logic [LINK_W-1:0] link;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] prefix;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FILTER_SCAN,
      ST_ROUTE_SCAN,
      ST_COUNT_RD,
      ST_COUNT_WR,
      ST_READ_RSP,
      ST_DONE
   } state_type;

   function automatic logic prefix_hit(entry_type e, logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] mask;
      mask = ~({ADDR_W{1'b1}} >> e.len);
      return ((addr ^ e.prefix) & mask) == '0;
   endfunction

endpackage

// ===== design/prfc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the route, filter and link counter stores; no dependencies.
module prfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/prefix_route_filter_counter.sv =====
// Top level of the prefix route filter counter: control sequencer and three RAMs.
// Depends on prfc_pkg and prfc_ram.
//
// Route and filter entries are appended to RAMs in arrival order; a packet scans the
// filters newest first and stops at the first hit; only on a filter miss does it scan
// every route, keeping the longest matching prefix (earliest entry on ties). Then it
// does a read-modify-write of the link counter RAM. The single read port of each RAM,
// one entry per cycle, sets the rate: packet time grows with the table sizes (less on a
// filter hit); a counter read passes ST_READ_RSP, adds and clear go straight to ST_DONE.
// Clear and reset take effect at once (no sweep).
// A new transaction is taken while the previous result still waits on rsp.
module prefix_route_filter_counter #(
   parameter int ROUTE_DEPTH  = prfc_pkg::ROUTE_DEPTH_DEF,
   parameter int FILTER_DEPTH = prfc_pkg::FILTER_DEPTH_DEF,
   parameter int LINK_COUNT   = prfc_pkg::LINK_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // address[31:0], prefix_len[37:32], link[41:38], zero[47:42]
   input  logic [prfc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[2:0]
   input  logic [prfc_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_link[3:0], matched[4], count[36:5], status[37], zero[39:38]
   output logic [prfc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import prfc_pkg::*;

   localparam int RAW     = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
   localparam int RCW     = $clog2(ROUTE_DEPTH + 1);
   localparam int FAW     = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int FCW     = $clog2(FILTER_DEPTH + 1);
   localparam int LINK_AW = $clog2(LINK_COUNT);
   localparam int LINK_IW = (LINK_AW > LINK_W) ? LINK_AW : LINK_W;

   state_type state_ff, state_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LINK_W-1:0] link_ff, link_in;

   logic [RCW-1:0] route_cnt_ff, route_cnt_in;
   logic [FCW-1:0] filt_cnt_ff, filt_cnt_in;
   logic [RCW-1:0] rptr_ff, rptr_in;
   logic [FCW-1:0] fptr_ff, fptr_in;
   logic           pend_ff, pend_in;

   logic              hit_ff, hit_in;
   logic [LINK_W-1:0] chosen_ff, chosen_in;
   logic [LEN_W-1:0]  best_ff, best_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic              status_ff, status_in;

   logic [LINK_COUNT-1:0] cvld_ff, cvld_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              rt_we, rt_re, ft_we, ft_re, ct_we, ct_re;
   logic [RAW-1:0]    rt_waddr, rt_raddr;
   logic [FAW-1:0]    ft_waddr, ft_raddr;
   logic [LINK_AW-1:0] ct_waddr, ct_raddr;
   logic [ENTRY_W-1:0] rt_rdata, ft_rdata;
   logic [ADDR_W-1:0]  ct_wdata, ct_rdata;
   entry_type          new_entry, rt_q, ft_q;

   logic [FCW-1:0]     fptr_dec;
   logic [LINK_IW-1:0] chosen_wide, link_wide;
   logic [LINK_AW-1:0] chosen_idx, link_idx;
   logic               chosen_ok, link_ok;

   assign new_entry   = '{link: link_ff, len: plen_ff, prefix: addr_ff};
   assign rt_q        = entry_type'(rt_rdata);
   assign ft_q        = entry_type'(ft_rdata);
   assign fptr_dec    = fptr_ff - FCW'(1);
   assign chosen_wide = LINK_IW'(chosen_ff);
   assign link_wide   = LINK_IW'(link_ff);
   assign chosen_idx  = chosen_wide[LINK_AW-1:0];
   assign link_idx    = link_wide[LINK_AW-1:0];
   assign chosen_ok   = 32'(chosen_ff) < LINK_COUNT;
   assign link_ok     = 32'(link_ff) < LINK_COUNT;

   assign rt_waddr = route_cnt_ff[RAW-1:0];
   assign rt_raddr = rptr_ff[RAW-1:0];
   assign ft_waddr = filt_cnt_ff[FAW-1:0];
   assign ft_raddr = fptr_dec[FAW-1:0];
   assign ct_waddr = chosen_idx;
   assign ct_wdata = (cvld_ff[chosen_idx] ? ct_rdata : '0) + ADDR_W'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      plen_in      = plen_ff;
      link_in      = link_ff;
      route_cnt_in = route_cnt_ff;
      filt_cnt_in  = filt_cnt_ff;
      rptr_in      = rptr_ff;
      fptr_in      = fptr_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      chosen_in    = chosen_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      cvld_in      = cvld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rt_we        = 1'b0;
      rt_re        = 1'b0;
      ft_we        = 1'b0;
      ft_re        = 1'b0;
      ct_we        = 1'b0;
      ct_re        = 1'b0;
      ct_raddr     = chosen_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               addr_in   = req_tdata[ADDR_W-1:0];
               plen_in   = (req_tdata[ADDR_W +: LEN_W] > MAX_LEN) ?
                           MAX_LEN : req_tdata[ADDR_W +: LEN_W];
               link_in   = req_tdata[ADDR_W+LEN_W +: LINK_W];
               hit_in    = 1'b0;
               chosen_in = '0;
               best_in   = '0;
               count_in  = '0;
               status_in = 1'b0;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            case (kind_ff)
               KIND_ADD_ROUTE: begin
                  if (route_cnt_ff == RCW'(ROUTE_DEPTH)) begin
                     status_in = 1'b1;
                  end else begin
                     rt_we        = 1'b1;
                     route_cnt_in = route_cnt_ff + RCW'(1);
                  end
               end
               KIND_ADD_FILTER: begin
                  if (filt_cnt_ff == FCW'(FILTER_DEPTH)) begin
                     status_in = 1'b1;
                  end else begin
                     ft_we       = 1'b1;
                     filt_cnt_in = filt_cnt_ff + FCW'(1);
                  end
               end
               KIND_PACKET: begin
                  fptr_in  = filt_cnt_ff;
                  rptr_in  = '0;
                  state_in = ST_FILTER_SCAN;
               end
               KIND_READ_COUNT: begin
                  ct_re    = 1'b1;
                  ct_raddr = link_idx;
                  state_in = ST_READ_RSP;
               end
               KIND_CLEAR: begin
                  route_cnt_in = '0;
                  filt_cnt_in  = '0;
                  cvld_in      = '0;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FILTER_SCAN: begin
            if (pend_ff && prefix_hit(ft_q, addr_ff)) begin
               hit_in    = 1'b1;
               chosen_in = ft_q.link;
               state_in  = ST_COUNT_RD;
            end else if (fptr_ff != '0) begin
               ft_re   = 1'b1;
               fptr_in = fptr_dec;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_ROUTE_SCAN;
            end
         end
         ST_ROUTE_SCAN: begin
            if (pend_ff && prefix_hit(rt_q, addr_ff) && (!hit_ff || rt_q.len > best_ff)) begin
               hit_in    = 1'b1;
               chosen_in = rt_q.link;
               best_in   = rt_q.len;
            end
            if (rptr_ff != route_cnt_ff) begin
               rt_re   = 1'b1;
               rptr_in = rptr_ff + RCW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_COUNT_RD;
            end
         end
         ST_COUNT_RD: begin
            if (chosen_ok) begin
               ct_re    = 1'b1;
               state_in = ST_COUNT_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COUNT_WR: begin
            ct_we               = 1'b1;
            cvld_in[chosen_idx] = 1'b1;
            state_in            = ST_DONE;
         end
         ST_READ_RSP: begin
            count_in = (link_ok && cvld_ff[link_idx]) ? ct_rdata : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({status_ff, count_ff, hit_ff, chosen_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         route_cnt_ff <= '0;
         filt_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         cvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         route_cnt_ff <= route_cnt_in;
         filt_cnt_ff  <= filt_cnt_in;
         pend_ff      <= pend_in;
         cvld_ff      <= cvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      plen_ff     <= plen_in;
      link_ff     <= link_in;
      rptr_ff     <= rptr_in;
      fptr_ff     <= fptr_in;
      hit_ff      <= hit_in;
      chosen_ff   <= chosen_in;
      best_ff     <= best_in;
      count_ff    <= count_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   prfc_ram #(.WIDTH(ENTRY_W), .DEPTH(ROUTE_DEPTH)) u_route_ram (
      .clock (clock),
      .we    (rt_we),
      .waddr (rt_waddr),
      .wdata (new_entry),
      .re    (rt_re),
      .raddr (rt_raddr),
      .rdata (rt_rdata)
   );

   prfc_ram #(.WIDTH(ENTRY_W), .DEPTH(FILTER_DEPTH)) u_filter_ram (
      .clock (clock),
      .we    (ft_we),
      .waddr (ft_waddr),
      .wdata (new_entry),
      .re    (ft_re),
      .raddr (ft_raddr),
      .rdata (ft_rdata)
   );

   prfc_ram #(.WIDTH(ADDR_W), .DEPTH(LINK_COUNT)) u_count_ram (
      .clock (clock),
      .we    (ct_we),
      .waddr (ct_waddr),
      .wdata (ct_wdata),
      .re    (ct_re),
      .raddr (ct_raddr),
      .rdata (ct_rdata)
   );

endmodule

// ===== design/prfc_checker.sv =====
// Port-level checker for the prefix route filter counter, bound to the top level.
// Depends on prfc_pkg for the port widths.
module prfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [prfc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import prfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction dropped or changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted again before the previous transaction was processed");

   a_link_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:0] != '0) |-> rsp_tdata[4])
      else $error("nonzero link reported without a match");

   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> (rsp_tdata[36:0] == '0))
      else $error("refused add reported with link, match or count");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind prefix_route_filter_counter prfc_checker u_prfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_prefix_route_filter_counter.sv =====
// Testbench for prefix_route_filter_counter: route/filter adds, packet lookups, counter
// reads and clears on the req stream, each response checked field by field on rsp.
// Depends on prfc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_prefix_route_filter_counter;
   import prfc_pkg::*;

   localparam int ROUTE_DEPTH  = ROUTE_DEPTH_DEF;
   localparam int FILTER_DEPTH = FILTER_DEPTH_DEF;
   localparam int LINK_COUNT   = LINK_COUNT_DEF;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DRAIN_CYCLES = 200;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int REPORT_MAX   = 10;
   localparam int POOL_SIZE    = 8;

   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [LINK_W-1:0] out_link;
      logic              matched;
      logic [31:0]       count;
      logic              status;
   } rsp_fields_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [ADDR_W-1:0] route_pfx [ROUTE_DEPTH];
   int unsigned       route_len [ROUTE_DEPTH];
   logic [LINK_W-1:0] route_link [ROUTE_DEPTH];
   int unsigned       route_num = 0;
   logic [ADDR_W-1:0] filt_pfx [FILTER_DEPTH];
   int unsigned       filt_len [FILTER_DEPTH];
   logic [LINK_W-1:0] filt_link [FILTER_DEPTH];
   int unsigned       filt_num = 0;
   logic [31:0]       link_hits [LINK_COUNT];
   logic [ADDR_W-1:0] prefix_pool [POOL_SIZE];

   rsp_fields_type awaited_rsp [$];
   int             mismatch_count = 0;
   longint         cycle_count = 0;
   bit             calm = 1'b0;
   int             rsp_hold = 0;

   prefix_route_filter_counter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask_of(int unsigned len);
      if (len == 0) return '0;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   // advance the lookup state by one transaction and return its response
   function automatic rsp_fields_type forward_and_count(logic [KIND_W-1:0] kind,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [LEN_W-1:0] len_raw,
                                                        logic [LINK_W-1:0] link);
      rsp_fields_type    r;
      int unsigned       len;
      int                pos;
      int                k;
      bit                hit;
      logic [LINK_W-1:0] chosen;
      r = '0;
      r.status = STATUS_OK;
      len = (len_raw > ADDR_W) ? ADDR_W : len_raw;
      case (kind)
         KIND_ADD_ROUTE: begin
            if (route_num >= ROUTE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < route_num && route_len[pos] >= len) pos++;
               for (k = route_num; k > pos; k--) begin
                  route_pfx[k]  = route_pfx[k-1];
                  route_len[k]  = route_len[k-1];
                  route_link[k] = route_link[k-1];
               end
               route_pfx[pos]  = addr;
               route_len[pos]  = len;
               route_link[pos] = link;
               route_num++;
            end
         end
         KIND_ADD_FILTER: begin
            if (filt_num >= FILTER_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               filt_pfx[filt_num]  = addr;
               filt_len[filt_num]  = len;
               filt_link[filt_num] = link;
               filt_num++;
            end
         end
         KIND_PACKET: begin
            hit = 1'b0;
            chosen = '0;
            for (k = int'(filt_num) - 1; k >= 0 && !hit; k--) begin
               if (((addr ^ filt_pfx[k]) & prefix_mask_of(filt_len[k])) == '0) begin
                  hit = 1'b1;
                  chosen = filt_link[k];
               end
            end
            for (k = 0; k < route_num && !hit; k++) begin
               if (((addr ^ route_pfx[k]) & prefix_mask_of(route_len[k])) == '0) begin
                  hit = 1'b1;
                  chosen = route_link[k];
               end
            end
            if (chosen < LINK_COUNT) link_hits[chosen] = link_hits[chosen] + 32'd1;
            r.out_link = chosen;
            r.matched = hit;
         end
         KIND_READ_COUNT: begin
            if (link < LINK_COUNT) r.count = link_hits[link];
         end
         KIND_CLEAR: begin
            route_num = 0;
            filt_num = 0;
            foreach (link_hits[i]) link_hits[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] len, input logic [LINK_W-1:0] link);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, link, len, addr};
      req_tuser  <= kind;
      awaited_rsp.push_back(forward_and_count(kind, addr, len, link));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // stall the response side, with calm stretches that keep it open
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap();
         rsp_tready <= (rsp_hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_link = rsp_tdata[3:0];
         got.matched  = rsp_tdata[4];
         got.count    = rsp_tdata[36:5];
         got.status   = rsp_tdata[37];
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response: link %0d matched %0b count %0d status %0b",
                        got.out_link, got.matched, got.count, got.status);
         end else begin
            want = awaited_rsp.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"mismatch: expected link %0d matched %0b count %0d status %0b,",
                            " got link %0d matched %0b count %0d status %0b"},
                           want.out_link, want.matched, want.count, want.status,
                           got.out_link, got.matched, got.count, got.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL prefix_route_filter_counter");
         $finish;
      end
   end

   task automatic test_empty_tables();
      logic [KIND_W-1:0] k;
      issue_request(KIND_PACKET, 32'h0A00_0001, '0, '0);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd0);
      issue_request(KIND_READ_COUNT, '1, '1, 4'd15);
      for (k = KIND_UNUSED_FIRST; k != KIND_ADD_ROUTE; k++) issue_request(k, '1, '1, '1);
      wait_drained();
   endtask

   task automatic test_lookup_order();
      issue_request(KIND_ADD_ROUTE, 32'h0000_0000, 6'd0, 4'd3);
      issue_request(KIND_ADD_ROUTE, 32'hFFFF_FFFF, 6'd32, 4'd15);
      issue_request(KIND_ADD_ROUTE, 32'h0000_0000, 6'd63, 4'd1);
      issue_request(KIND_ADD_ROUTE, 32'h0A00_0000, 6'd8, 4'd2);
      issue_request(KIND_ADD_ROUTE, 32'h0A00_0000, 6'd8, 4'd4);
      issue_request(KIND_ADD_ROUTE, 32'h0A01_0000, 6'd16, 4'd5);
      issue_request(KIND_PACKET, 32'hFFFF_FFFF, '0, '0);
      issue_request(KIND_PACKET, 32'h0000_0000, '0, '0);
      issue_request(KIND_PACKET, 32'h0A01_FFFF, '0, '0);
      issue_request(KIND_PACKET, 32'h0AFF_0000, '0, '0);
      issue_request(KIND_PACKET, 32'h7F00_0001, '0, '0);
      issue_request(KIND_ADD_FILTER, 32'h0A00_0000, 6'd8, 4'd6);
      issue_request(KIND_PACKET, 32'h0A01_0203, '0, '0);
      issue_request(KIND_ADD_FILTER, 32'h0A01_0200, 6'd24, 4'd7);
      issue_request(KIND_PACKET, 32'h0A01_0203, '0, '0);
      issue_request(KIND_PACKET, 32'h0A02_0000, '0, '0);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd15);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd1);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd6);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd7);
      issue_request(KIND_CLEAR, '0, '0, '0);
      issue_request(KIND_PACKET, 32'h0A01_0203, '0, '0);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd7);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd0);
      wait_drained();
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return LEN_W'($urandom_range(33, 63));
      if (r == 1) return '0;
      return LEN_W'($urandom_range(1, 32));
   endfunction

   task automatic test_table_full();
      int i;
      for (i = 0; i <= ROUTE_DEPTH; i++)
         issue_request(KIND_ADD_ROUTE, $urandom(), pick_len(), LINK_W'($urandom_range(0, 15)));
      issue_request(KIND_PACKET, $urandom(), '0, '0);
      for (i = 0; i <= FILTER_DEPTH; i++)
         issue_request(KIND_ADD_FILTER, $urandom(), pick_len(), LINK_W'($urandom_range(0, 15)));
      issue_request(KIND_PACKET, $urandom(), '0, '0);
      issue_request(KIND_READ_COUNT, '0, '0, 4'd0);
      issue_request(KIND_CLEAR, '0, '0, '0);
      wait_drained();
   endtask

   function automatic logic [ADDR_W-1:0] pick_prefix();
      if ($urandom_range(0, 9) < 7)
         return (prefix_pool[$urandom_range(0, POOL_SIZE-1)] & 32'hFFFF_F000) |
                ($urandom() & 32'h0000_0FFF);
      return $urandom();
   endfunction

   // mostly addresses that fall under a stored prefix, so lookups hit deep entries
   function automatic logic [ADDR_W-1:0] pick_destination();
      int unsigned       idx;
      logic [ADDR_W-1:0] m;
      if (route_num + filt_num == 0 || $urandom_range(0, 9) < 3) return $urandom();
      idx = $urandom_range(0, route_num + filt_num - 1);
      if (idx < route_num) begin
         m = prefix_mask_of(route_len[idx]);
         return (route_pfx[idx] & m) | ($urandom() & ~m);
      end
      m = prefix_mask_of(filt_len[idx - route_num]);
      return (filt_pfx[idx - route_num] & m) | ($urandom() & ~m);
   endfunction

   task automatic test_random_traffic();
      int issued;
      int run_len;
      int route_weight;
      int filter_weight;
      int i;
      int r;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         foreach (prefix_pool[p]) prefix_pool[p] = $urandom();
         run_len = $urandom_range(20, 160);
         case ($urandom_range(0, 2))
            0: route_weight = 8;
            1: route_weight = 25;
            default: route_weight = 60;
         endcase
         filter_weight = $urandom_range(3, 15);
         for (i = 0; i < run_len && issued < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               issue_request(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                             $urandom(), LEN_W'($urandom()), LINK_W'($urandom()));
               continue;
            end
            r = $urandom_range(0, 99);
            if (r < route_weight)
               issue_request(KIND_ADD_ROUTE, pick_prefix(), pick_len(),
                             LINK_W'($urandom_range(0, 15)));
            else if (r < route_weight + filter_weight)
               issue_request(KIND_ADD_FILTER, pick_prefix(), pick_len(),
                             LINK_W'($urandom_range(0, 15)));
            else if (r < 88)
               issue_request(KIND_PACKET, pick_destination(), LEN_W'($urandom()),
                             LINK_W'($urandom()));
            else if (r < 99)
               issue_request(KIND_READ_COUNT, $urandom(), LEN_W'($urandom()),
                             LINK_W'($urandom_range(0, 15)));
            else
               issue_request(KIND_CLEAR, $urandom(), LEN_W'($urandom()), LINK_W'($urandom()));
            issued++;
         end
         issue_request(KIND_CLEAR, '0, '0, '0);
         issued++;
      end
      calm = 1'b0;
      wait_drained();
   endtask

   initial begin
      foreach (link_hits[i]) link_hits[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tables();
      test_lookup_order();
      test_table_full();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("PASS prefix_route_filter_counter");
      end else begin
         $display("FAIL prefix_route_filter_counter");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/prfc_pkg.sv
design/prfc_ram.sv
design/prefix_route_filter_counter.sv
design/prfc_checker.sv
dv/tb_prefix_route_filter_counter.sv
